>>> sv/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Holds the item structs, the phase enum, request and status codes.
// No dependencies.
package i2cms_pkg;

  localparam int unsigned TXB_DEPTH = 16;
  localparam int unsigned TXB_AW    = $clog2(TXB_DEPTH);
  localparam int unsigned CNT_W     = 5;
  localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(16);

  // request types
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;

  // engine status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PENDING = 3'd1,
    PH_BUSY    = 3'd2,
    PH_DONE    = 3'd3,
    PH_FAIL    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TXB_AW-1:0] load_index;
    logic [7:0]        load_byte;
    logic              is_read;
    logic [6:0]        slave_addr;
    logic [7:0]        slave_reg;
    logic [CNT_W-1:0]  byte_count;
    logic [7:0]        status_code;
    logic [7:0]        rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              data_write_valid;
    logic [7:0]        data_write_byte;
    logic              set_start;
    logic              clear_start;
    logic              set_stop;
    logic              set_ack;
    logic              clear_ack;
    logic              bus_enable;
    logic              rx_valid;
    logic [TXB_AW-1:0] rx_index;
    logic [2:0]        transfer_state;
  } out_item_t;

endpackage

>>> sv/i2cms_in_reg.sv
// Input register stage of the transfer sequencer.
// Captures one beat and holds it until the result register takes it.
// Depends on i2cms_pkg.
module i2cms_in_reg
  import i2cms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> sv/i2cms_seq.sv
// Transfer state and status-event decoder of the sequencer.
// Holds phase, counters, target and transmit buffer; decides one result per beat.
// Depends on i2cms_pkg.
module i2cms_seq
  import i2cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_item_t  item,
  output out_item_t res
);

  phase_t            phase_r, phase_nxt;
  logic              read_pending_r, read_pending_nxt;
  logic [CNT_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [TXB_AW-1:0] byte_pos_r, byte_pos_nxt;
  logic [6:0]        target_addr_r, target_addr_nxt;
  logic [7:0]        target_reg_r, target_reg_nxt;
  logic [7:0]        txb_r [TXB_DEPTH];

  logic             active;
  logic [CNT_W-1:0] cnt_sat;
  logic [7:0]       tx_byte;

  assign active  = (item.req_type == REQ_EVENT) &&
                   (phase_r == PH_PENDING || phase_r == PH_BUSY);
  assign cnt_sat = (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;
  assign tx_byte = txb_r[byte_pos_r];

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    read_pending_nxt = read_pending_r;
    bytes_left_nxt   = bytes_left_r;
    byte_pos_nxt     = byte_pos_r;
    target_addr_nxt  = target_addr_r;
    target_reg_nxt   = target_reg_r;
    if (item.req_type == REQ_START) begin
      read_pending_nxt = item.is_read;
      target_addr_nxt  = item.slave_addr;
      target_reg_nxt   = item.slave_reg;
      bytes_left_nxt   = cnt_sat;
      byte_pos_nxt     = '0;
      phase_nxt        = PH_PENDING;
    end else if (active) begin
      case (item.status_code)
        ST_START:     phase_nxt = PH_BUSY;
        ST_RSTART:    ;
        ST_SLA_W_ACK: ;
        ST_SLA_R_ACK: ;
        ST_DATA_TX_ACK: begin
          if (read_pending_r) begin
            read_pending_nxt = 1'b0;
          end else if (bytes_left_r != '0) begin
            byte_pos_nxt   = byte_pos_r + 1'b1;
            bytes_left_nxt = bytes_left_r - 1'b1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        ST_DATA_RX_ACK: begin
          byte_pos_nxt = byte_pos_r + 1'b1;
          if (bytes_left_r != '0) begin
            bytes_left_nxt = bytes_left_r - 1'b1;
          end
        end
        ST_DATA_RX_NACK: begin
          byte_pos_nxt = byte_pos_r + 1'b1;
          phase_nxt    = PH_DONE;
        end
        default: phase_nxt = PH_FAIL;
      endcase
    end
  end

  // result fields
  always_comb begin
    res                = '0;
    res.bus_enable     = (phase_nxt == PH_PENDING) || (phase_nxt == PH_BUSY);
    res.transfer_state = phase_nxt;
    if (item.req_type == REQ_START) begin
      res.set_start = 1'b1;
    end else if (active) begin
      case (item.status_code)
        ST_START: begin
          res.data_write_valid = 1'b1;
          res.data_write_byte  = {target_addr_r, 1'b0};
          res.clear_start      = 1'b1;
        end
        ST_RSTART: begin
          res.data_write_valid = 1'b1;
          res.data_write_byte  = {target_addr_r, 1'b1};
          res.clear_start      = 1'b1;
        end
        ST_SLA_W_ACK: begin
          res.data_write_valid = 1'b1;
          res.data_write_byte  = target_reg_r;
        end
        ST_SLA_W_NACK: res.set_stop = 1'b1;
        ST_DATA_TX_ACK: begin
          if (read_pending_r) begin
            res.set_start = 1'b1;
          end else if (bytes_left_r != '0) begin
            res.data_write_valid = 1'b1;
            res.data_write_byte  = tx_byte;
          end else begin
            res.set_stop = 1'b1;
          end
        end
        ST_SLA_R_ACK:  res.set_ack  = (bytes_left_r > CNT_W'(1));
        ST_SLA_R_NACK: res.set_stop = 1'b1;
        ST_DATA_RX_ACK: begin
          res.rx_valid  = 1'b1;
          res.rx_index  = byte_pos_r;
          res.clear_ack = (bytes_left_r == CNT_W'(2));
        end
        ST_DATA_RX_NACK: begin
          res.rx_valid = 1'b1;
          res.rx_index = byte_pos_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      read_pending_r <= 1'b0;
      bytes_left_r   <= '0;
      byte_pos_r     <= '0;
      target_addr_r  <= '0;
      target_reg_r   <= '0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      read_pending_r <= read_pending_nxt;
      bytes_left_r   <= bytes_left_nxt;
      byte_pos_r     <= byte_pos_nxt;
      target_addr_r  <= target_addr_nxt;
      target_reg_r   <= target_reg_nxt;
    end
  end

  // transmit buffer, no reset
  always_ff @(posedge clk) begin
    if (adv && item.req_type == REQ_LOAD) begin
      txb_r[item.load_index] <= item.load_byte;
    end
  end

endmodule

>>> sv/i2cms_out_reg.sv
// Result register of the transfer sequencer.
// Holds one finished result beat until the receiver takes it.
// Depends on i2cms_pkg.
module i2cms_out_reg
  import i2cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      load,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign load      = res_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

>>> sv/i2c_master_transfer_sequencer_unit.sv
// I2C master register transfer sequencer, top level.
// Input channel (in_valid/in_ready) takes three kinds of beats: a transmit byte
// load into the 16-slot buffer, a transfer start (direction, target address,
// register, byte count) and a status event from the byte-level I2C engine.
// Every input beat yields exactly one result beat on out_valid/out_ready,
// carrying the engine commands (data register write, START/STOP/ACK control),
// the enable level, a captured-byte marker and the transfer phase.
// Path: an accepted beat sits in the input register, is decoded against the
// transfer state and is written into the result register once that register
// is empty or being read; out_valid is high while it holds the result.
// Throughput: one beat per cycle; the decode is a single case on the held
// state and the transfer state advances as each beat enters the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; after that in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers and returns the
// transfer to idle; the transmit buffer is not cleared and must be loaded
// before the bytes of a write are sent.
// Depends on i2cms_pkg, i2cms_in_reg, i2cms_seq and i2cms_out_reg.
module i2c_master_transfer_sequencer_unit
  import i2cms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [TXB_AW-1:0]     in_load_index,
  input  logic [7:0]            in_load_byte,
  input  logic                  in_is_read,
  input  logic [6:0]            in_slave_addr,
  input  logic [7:0]            in_slave_reg,
  input  logic [CNT_W-1:0]      in_byte_count,
  input  logic [7:0]            in_status_code,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_data_write_valid,
  output logic [7:0]            out_data_write_byte,
  output logic                  out_set_start,
  output logic                  out_clear_start,
  output logic                  out_set_stop,
  output logic                  out_set_ack,
  output logic                  out_clear_ack,
  output logic                  out_bus_enable,
  output logic                  out_rx_valid,
  output logic [TXB_AW-1:0]     out_rx_index,
  output logic [2:0]            out_transfer_state
);

  in_item_t  in_item;
  in_item_t  item;
  logic      item_valid;
  logic      adv;
  out_item_t res;
  out_item_t out_item;

  assign in_item = '{
    req_type:    in_req_type,
    load_index:  in_load_index,
    load_byte:   in_load_byte,
    is_read:     in_is_read,
    slave_addr:  in_slave_addr,
    slave_reg:   in_slave_reg,
    byte_count:  in_byte_count,
    status_code: in_status_code,
    rx_byte:     in_rx_byte
  };

  i2cms_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cms_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  i2cms_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .load      (adv),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_data_write_valid = out_item.data_write_valid;
  assign out_data_write_byte  = out_item.data_write_byte;
  assign out_set_start        = out_item.set_start;
  assign out_clear_start      = out_item.clear_start;
  assign out_set_stop         = out_item.set_stop;
  assign out_set_ack          = out_item.set_ack;
  assign out_clear_ack        = out_item.clear_ack;
  assign out_bus_enable       = out_item.bus_enable;
  assign out_rx_valid         = out_item.rx_valid;
  assign out_rx_index         = out_item.rx_index;
  assign out_transfer_state   = out_item.transfer_state;

  // a beat leaving the input register always shows up as a result next cycle
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("decoded beat did not reach the result register");

  // enable level follows the reported phase
  a_enable_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bus_enable ==
      (out_transfer_state == PH_PENDING || out_transfer_state == PH_BUSY)))
    else $error("bus enable disagrees with transfer phase");

  // never request and withdraw START in the same beat
  a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_set_start && out_clear_start))
    else $error("START set and cleared together");

  // idle payload fields stay zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data_write_valid || out_data_write_byte == 8'd0) &&
                   (out_rx_valid || out_rx_index == '0)))
    else $error("unused result field is not zero");

endmodule
